### src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for clocked assertions with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent is checked in the cycle after the antecedent.
`define LWO_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("waveshaper check failed");

// The consequent is checked in the cycle of the antecedent.
`define LWO_ASSERT_SAME(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("waveshaper check failed");

`endif

### src/lwo_pkg.sv
// ----------------------------------------------------------------------------
// Waveshaper overdrive package
// Types, codes and fixed widths shared by the controller and the datapath.
// ----------------------------------------------------------------------------
package lwo_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int TADDR_W    = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int MUL_A_W    = 25;
  localparam int MUL_B_W    = 18;
  localparam int PROD_W     = 43;

  localparam logic [15:0] UNITY_Q15 = 16'd32768;

  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_GAIN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TONE_COEFF     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WET_VOLUME     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIX_AMOUNT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EFFECT_ENABLED = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TABLE_READY    = 3'd5;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DECODE, ST_WRITE, ST_PASS, ST_GAIN, ST_CLIP, ST_POS, ST_ADDR,
    ST_RD0, ST_RD1, ST_DIFF, ST_INTERP, ST_WS, ST_LPA, ST_LPB, ST_LP, ST_WET,
    ST_WETR, ST_MIXA, ST_MIXB, ST_MAG, ST_SCALE
  } lwo_state_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_WRITE, OP_PASS, OP_GAIN, OP_CLIP, OP_POS, OP_ADDR, OP_RD0,
    OP_RD1, OP_DIFF, OP_INTERP, OP_WS, OP_LPA, OP_LPB, OP_LP, OP_WET, OP_WETR,
    OP_MIXA, OP_MIXB, OP_MAG, OP_SCALE
  } lwo_op_e;

  typedef struct packed {
    logic    load_in;
    logic    load_out;
    lwo_op_e op;
  } lwo_cmd_t;

  typedef struct packed {
    logic kind;
    logic table_ready;
  } lwo_stat_t;

endpackage

### src/lwo_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write or read per cycle, read data registered.
// ----------------------------------------------------------------------------
module lwo_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### src/lwo_ctrl.sv
// ----------------------------------------------------------------------------
// Waveshaper controller
// Sequences the datapath through one word and owns the output valid flag.
// ----------------------------------------------------------------------------
module lwo_ctrl import lwo_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  input  lwo_stat_t stat_i,
  output lwo_cmd_t  cmd_o
);

  lwo_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        if (stat_i.kind) begin
          state_d = ST_WRITE;
        end else if (!stat_i.table_ready) begin
          state_d = ST_PASS;
        end else begin
          state_d = ST_GAIN;
        end
      end
      ST_WRITE:  state_d = ST_IDLE;
      ST_PASS: begin
        if (out_free) state_d = ST_IDLE;
      end
      ST_GAIN:   state_d = ST_CLIP;
      ST_CLIP:   state_d = ST_POS;
      ST_POS:    state_d = ST_ADDR;
      ST_ADDR:   state_d = ST_RD0;
      ST_RD0:    state_d = ST_RD1;
      ST_RD1:    state_d = ST_DIFF;
      ST_DIFF:   state_d = ST_INTERP;
      ST_INTERP: state_d = ST_WS;
      ST_WS:     state_d = ST_LPA;
      ST_LPA:    state_d = ST_LPB;
      ST_LPB:    state_d = ST_LP;
      ST_LP:     state_d = ST_WET;
      ST_WET:    state_d = ST_WETR;
      ST_WETR:   state_d = ST_MIXA;
      ST_MIXA:   state_d = ST_MIXB;
      ST_MIXB:   state_d = ST_MAG;
      ST_MAG:    state_d = ST_SCALE;
      ST_SCALE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.load_in  = 1'b0;
    cmd_o.load_out = 1'b0;
    cmd_o.op       = OP_NONE;
    unique case (state_q)
      ST_IDLE:   cmd_o.load_in = in_valid_i;
      ST_DECODE: cmd_o.op = OP_NONE;
      ST_WRITE:  cmd_o.op = OP_WRITE;
      ST_PASS: begin
        cmd_o.op       = OP_PASS;
        cmd_o.load_out = out_free;
      end
      ST_GAIN:   cmd_o.op = OP_GAIN;
      ST_CLIP:   cmd_o.op = OP_CLIP;
      ST_POS:    cmd_o.op = OP_POS;
      ST_ADDR:   cmd_o.op = OP_ADDR;
      ST_RD0:    cmd_o.op = OP_RD0;
      ST_RD1:    cmd_o.op = OP_RD1;
      ST_DIFF:   cmd_o.op = OP_DIFF;
      ST_INTERP: cmd_o.op = OP_INTERP;
      ST_WS:     cmd_o.op = OP_WS;
      ST_LPA:    cmd_o.op = OP_LPA;
      ST_LPB:    cmd_o.op = OP_LPB;
      ST_LP:     cmd_o.op = OP_LP;
      ST_WET:    cmd_o.op = OP_WET;
      ST_WETR:   cmd_o.op = OP_WETR;
      ST_MIXA:   cmd_o.op = OP_MIXA;
      ST_MIXB:   cmd_o.op = OP_MIXB;
      ST_MAG:    cmd_o.op = OP_MAG;
      ST_SCALE: begin
        cmd_o.op       = OP_SCALE;
        cmd_o.load_out = out_free;
      end
      default:   cmd_o.op = OP_NONE;
    endcase
  end

  assign out_valid_d = cmd_o.load_out || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

### src/lwo_dp.sv
// ----------------------------------------------------------------------------
// Waveshaper datapath
// Configuration registers, shaping table, shared multiplier and filter state.
// ----------------------------------------------------------------------------
module lwo_dp import lwo_pkg::*; #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic                       kind_i,
  input  logic signed [SAMPLE_W-1:0] sample_in_i,
  input  logic [TADDR_W-1:0]         table_addr_i,
  input  logic signed [SAMPLE_W-1:0] table_word_i,
  input  lwo_cmd_t                   cmd_i,
  output lwo_stat_t                  stat_o,
  output logic signed [SAMPLE_W-1:0] sample_out_o
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int IW = AW + 1;

  logic [14:0] drive_gain_q;
  logic [15:0] tone_coeff_q, wet_volume_q, mix_amount_q;
  logic        effect_enabled_q, table_ready_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drive_gain_q     <= 15'd1024;
      tone_coeff_q     <= 16'd16384;
      wet_volume_q     <= 16'd32768;
      mix_amount_q     <= 16'd0;
      effect_enabled_q <= 1'b0;
      table_ready_q    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_DRIVE_GAIN:     drive_gain_q     <= cfg_wdata_i[14:0];
        REG_TONE_COEFF:     tone_coeff_q     <= cfg_wdata_i;
        REG_WET_VOLUME:     wet_volume_q     <= cfg_wdata_i;
        REG_MIX_AMOUNT:     mix_amount_q     <= cfg_wdata_i;
        REG_EFFECT_ENABLED: effect_enabled_q <= cfg_wdata_i[0];
        REG_TABLE_READY:    table_ready_q    <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  logic [15:0] a0, a0_fb, vol, mix, mix_fb;

  assign a0     = (tone_coeff_q > UNITY_Q15) ? UNITY_Q15 : tone_coeff_q;
  assign a0_fb  = UNITY_Q15 - a0;
  assign vol    = (wet_volume_q > UNITY_Q15) ? UNITY_Q15 : wet_volume_q;
  assign mix    = !effect_enabled_q ? 16'd0 :
                  ((mix_amount_q > UNITY_Q15) ? UNITY_Q15 : mix_amount_q);
  assign mix_fb = UNITY_Q15 - mix;

  logic                       kind_q;
  logic signed [SAMPLE_W-1:0] x_q;
  logic [TADDR_W-1:0]         taddr_q;
  logic [SAMPLE_W-1:0]        tword_q;

  logic signed [PROD_W-1:0]  prod_q, acc_q;
  logic [16:0]               u_q;
  logic [AW-1:0]             i0_q, i1_q;
  logic [15:0]               frac_q;
  logic [SAMPLE_W-1:0]       y0_q;
  logic signed [16:0]        diff_q, ws_q;
  logic signed [23:0]        z_q;
  logic signed [24:0]        wet_q, y_q;
  logic [23:0]               mag_q;
  logic                      neg_q;
  logic signed [SAMPLE_W-1:0] out_q;

  logic [SAMPLE_W-1:0] rdata;
  logic [31:0]         waddr_w;
  logic                mem_we;
  logic [AW-1:0]       mem_addr;

  assign waddr_w  = 32'(taddr_q);
  assign mem_we   = (cmd_i.op == OP_WRITE) && (waddr_w < TABLE_DEPTH);
  assign mem_addr = (cmd_i.op == OP_WRITE) ? waddr_w[AW-1:0] :
                    ((cmd_i.op == OP_RD1) ? i1_q : i0_q);

  lwo_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .addr_i (mem_addr),
    .wdata_i(tword_q),
    .rdata_o(rdata)
  );

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod_d;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      OP_GAIN: begin
        mul_a = {{9{x_q[15]}}, x_q};
        mul_b = $signed({3'b000, drive_gain_q});
      end
      OP_POS: begin
        mul_a = $signed({8'b0, u_q});
        mul_b = MUL_B_W'(TABLE_DEPTH - 1);
      end
      OP_INTERP: begin
        mul_a = {{8{diff_q[16]}}, diff_q};
        mul_b = $signed({2'b00, frac_q});
      end
      OP_LPA: begin
        mul_a = {{8{ws_q[16]}}, ws_q};
        mul_b = $signed({2'b00, a0});
      end
      OP_LPB: begin
        mul_a = {z_q[23], z_q};
        mul_b = $signed({2'b00, a0_fb});
      end
      OP_WET: begin
        mul_a = {z_q[23], z_q};
        mul_b = $signed({2'b00, vol});
      end
      OP_WETR: begin
        mul_a = {{9{x_q[15]}}, x_q};
        mul_b = $signed({2'b00, mix_fb});
      end
      OP_MIXA: begin
        mul_a = wet_q;
        mul_b = $signed({2'b00, mix});
      end
      default: ;
    endcase
  end

  assign prod_d = mul_a * mul_b;

  logic signed [PROD_W-1:0] gain_r, interp_r, sum_w, sum_r, wet_r;
  logic [IW-1:0]            i0_full;
  logic [AW-1:0]            i0_w;
  logic [38:0]              scaled_w;
  logic [SAMPLE_W-1:0]      sc_w;
  logic signed [SAMPLE_W-1:0] res_w;

  assign gain_r   = (prod_q + 43'sd512) >>> 10;
  assign interp_r = (prod_q + 43'sd32768) >>> 16;
  assign wet_r    = (prod_q + 43'sd16384) >>> 15;
  assign sum_w    = acc_q + prod_q;
  assign sum_r    = (sum_w + 43'sd16384) >>> 15;
  assign i0_full  = prod_q[16 +: IW];
  assign i0_w     = (i0_full > IW'(TABLE_DEPTH - 1)) ? AW'(TABLE_DEPTH - 1)
                                                     : i0_full[AW-1:0];
  assign scaled_w = {mag_q, 15'b0} - {15'b0, mag_q};
  assign sc_w     = scaled_w[38:23];
  assign res_w    = neg_q ? $signed(-sc_w) : $signed(sc_w);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      z_q <= '0;
    end else if (cmd_i.op == OP_LP) begin
      if (sum_r < -43'sd8388608) begin
        z_q <= -24'sd8388608;
      end else if (sum_r > 43'sd8388607) begin
        z_q <= 24'sd8388607;
      end else begin
        z_q <= sum_r[23:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (cmd_i.load_in) begin
      kind_q  <= kind_i;
      x_q     <= sample_in_i;
      taddr_q <= table_addr_i;
      tword_q <= table_word_i;
    end
    case (cmd_i.op)
      OP_CLIP: begin
        if (gain_r < -43'sd32768) begin
          u_q <= 17'd0;
        end else if (gain_r > 43'sd32768) begin
          u_q <= 17'd65536;
        end else begin
          u_q <= gain_r[16:0] + 17'd32768;
        end
      end
      OP_ADDR: begin
        i0_q   <= i0_w;
        i1_q   <= (i0_w == AW'(TABLE_DEPTH - 1)) ? i0_w : i0_w + 1'b1;
        frac_q <= prod_q[15:0];
      end
      OP_RD1:  y0_q <= rdata;
      OP_DIFF: diff_q <= $signed({rdata[15], rdata}) - $signed({y0_q[15], y0_q});
      OP_WS:   ws_q <= $signed({y0_q[15], y0_q}) + interp_r[16:0];
      OP_LPB:  acc_q <= prod_q <<< 8;
      OP_WETR: wet_q <= wet_r[24:0];
      OP_MIXA: acc_q <= prod_q <<< 8;
      OP_MIXB: begin
        if (sum_r < -43'sd8388608) begin
          y_q <= -25'sd8388608;
        end else if (sum_r > 43'sd8388608) begin
          y_q <= 25'sd8388608;
        end else begin
          y_q <= sum_r[24:0];
        end
      end
      OP_MAG: begin
        mag_q <= y_q[24] ? 24'(-y_q) : y_q[23:0];
        neg_q <= y_q[24];
      end
      default: ;
    endcase
    if (cmd_i.load_out) begin
      out_q <= (cmd_i.op == OP_PASS) ? x_q : res_w;
    end
  end

  assign stat_o.kind        = kind_q;
  assign stat_o.table_ready = table_ready_q;
  assign sample_out_o       = out_q;

endmodule

### src/lut_waveshaper_overdrive_top.sv
// Audio sample: gain, clip, position, address, table reads, interpolation, shaping,
// low-pass, wet, mix, magnitude and scale in turn, sharing the single 25x18 multiplier
// and table RAM port, one word at a time; pass-throughs and table writes skip them.
// A finished result waits in the output register while the next word is accepted.
// Reset loads the register reset values and clears the low-pass state; the table
// holds undefined contents until written and gets no clearing pass.
// ----------------------------------------------------------------------------
// LUT waveshaper overdrive
// Drive, table shaping with interpolation, one-pole low-pass, volume and mix.
// ----------------------------------------------------------------------------
module lut_waveshaper_overdrive_top import lwo_pkg::*; #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       kind_i,
  input  logic signed [SAMPLE_W-1:0] sample_in_i,
  input  logic [TADDR_W-1:0]         table_addr_i,
  input  logic signed [SAMPLE_W-1:0] table_word_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [SAMPLE_W-1:0] sample_out_o
);

  lwo_cmd_t  cmd;
  lwo_stat_t stat;

  lwo_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  lwo_dp #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .kind_i      (kind_i),
    .sample_in_i (sample_in_i),
    .table_addr_i(table_addr_i),
    .table_word_i(table_word_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .sample_out_o(sample_out_o)
  );

endmodule

### src/lwo_checker.sv
// ----------------------------------------------------------------------------
// Waveshaper port checker
// Watches the top-level ports for handshake and sequencing slips.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lwo_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        kind_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] sample_out_o
);

  `LWO_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
  `LWO_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(sample_out_o))
  `LWO_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
  `LWO_ASSERT_SAME(a_write_no_result, clk_i, rst_ni, in_valid_i && !in_stall_o && kind_i && !out_valid_o, ##1 !out_valid_o ##1 !out_valid_o ##1 !out_valid_o)

endmodule

bind lut_waveshaper_overdrive_top lwo_checker u_lwo_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .kind_i      (kind_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .sample_out_o(sample_out_o)
);

### sim/tb_lut_waveshaper_overdrive_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Waveshaper overdrive testbench
// Drives audio samples and shaping table writes through the valid/stall
// channel with random gaps and output stalls, mirrors the block in an integer
// predictor and compares every output word against it in order.
// ----------------------------------------------------------------------------
module tb_lut_waveshaper_overdrive_top;
  import lwo_pkg::*;

  localparam int TABLE_DEPTH = 1024;
  localparam int SETTLE_CYCLES = 24;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_WORDS = 120;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_TABLE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  typedef struct packed {
    logic                       kind;
    logic signed [SAMPLE_W-1:0] sample;
    logic [TADDR_W-1:0]         addr;
    logic signed [SAMPLE_W-1:0] word;
  } drive_word_t;

  typedef enum {ROW_WORD, ROW_REG} row_op_e;

  typedef struct {
    row_op_e op;
    logic    kind;
    int      sample;
    int      sel;
    int      data;
    bit      typed;
    int      result;
  } script_row_t;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       cfg_we_i;
  logic [CFG_IDX_W-1:0]       cfg_index_i;
  logic [CFG_DATA_W-1:0]      cfg_wdata_i;
  logic                       in_valid_i;
  logic                       in_stall_o;
  logic                       kind_i;
  logic signed [SAMPLE_W-1:0] sample_in_i;
  logic [TADDR_W-1:0]         table_addr_i;
  logic signed [SAMPLE_W-1:0] table_word_i;
  logic                       out_valid_o;
  logic                       out_stall_i;
  logic signed [SAMPLE_W-1:0] sample_out_o;

  // Predictor state and register mirror.
  logic signed [SAMPLE_W-1:0] shape_lut [TABLE_DEPTH];
  bit [TABLE_DEPTH-1:0]       lut_written;
  longint                     lowpass_z;
  logic [14:0]                gain_q10;
  logic [15:0]                tone_a0;
  logic [15:0]                wet_level;
  logic [15:0]                blend;
  logic                       fx_on;
  logic                       lut_live;

  logic signed [SAMPLE_W-1:0] sample_out_due [$];
  logic signed [SAMPLE_W-1:0] due_word;
  int                         mismatches;
  int                         cycle_count;
  int                         words_taken;
  int                         hold_cycles;
  bit                         sender_calm;
  bit                         receiver_calm;

  script_row_t script [0:31] = '{
    '{ROW_WORD, KIND_SAMPLE, 0, 0, 0, 1, 0},
    '{ROW_WORD, KIND_SAMPLE, 32767, 0, 0, 1, 32767},
    '{ROW_WORD, KIND_SAMPLE, -32768, 0, 0, 1, -32768},
    '{ROW_WORD, KIND_SAMPLE, 21845, 1023, 0, 1, 21845},
    '{ROW_WORD, KIND_SAMPLE, -21846, 682, -32767, 1, -21846},
    '{ROW_WORD, KIND_TABLE, 0, 0, -32767, 0, 0},
    '{ROW_WORD, KIND_TABLE, -1, 1023, 32767, 0, 0},
    '{ROW_WORD, KIND_TABLE, 0, 511, 0, 0, 0},
    '{ROW_WORD, KIND_TABLE, 0, 512, 21845, 0, 0},
    '{ROW_REG, KIND_SAMPLE, 0, REG_TABLE_READY, 1, 0, 0},
    '{ROW_REG, KIND_SAMPLE, 0, REG_EFFECT_ENABLED, 1, 0, 0},
    '{ROW_REG, KIND_SAMPLE, 0, REG_MIX_AMOUNT, 32768, 0, 0},
    '{ROW_REG, KIND_SAMPLE, 0, REG_TONE_COEFF, 32768, 0, 0},
    '{ROW_REG, KIND_SAMPLE, 0, REG_WET_VOLUME, 32768, 0, 0},
    '{ROW_WORD, KIND_SAMPLE, -32768, 0, 0, 0, 0},
    '{ROW_WORD, KIND_SAMPLE, 32767, 0, 0, 0, 0},
    '{ROW_REG, KIND_SAMPLE, 0, REG_DRIVE_GAIN, 32767, 0, 0},
    '{ROW_WORD, KIND_SAMPLE, 32767, 0, 0, 0, 0},
    '{ROW_WORD, KIND_SAMPLE, -32768, 0, 0, 0, 0},
    '{ROW_WORD, KIND_SAMPLE, 100, 0, 0, 0, 0},
    '{ROW_REG, KIND_SAMPLE, 0, REG_DRIVE_GAIN, 0, 0, 0},
    '{ROW_WORD, KIND_SAMPLE, 12345, 0, 0, 0, 0},
    '{ROW_REG, KIND_SAMPLE, 0, REG_TONE_COEFF, 65535, 0, 0},
    '{ROW_REG, KIND_SAMPLE, 0, REG_WET_VOLUME, 65535, 0, 0},
    '{ROW_REG, KIND_SAMPLE, 0, REG_MIX_AMOUNT, 65535, 0, 0},
    '{ROW_WORD, KIND_SAMPLE, -7, 0, 0, 0, 0},
    '{ROW_REG, KIND_SAMPLE, 0, REG_TONE_COEFF, 0, 0, 0},
    '{ROW_WORD, KIND_SAMPLE, 4000, 0, 0, 0, 0},
    '{ROW_REG, KIND_SAMPLE, 0, REG_SPARE_B, 65535, 0, 0},
    '{ROW_WORD, KIND_SAMPLE, 3000, 0, 0, 0, 0},
    '{ROW_REG, KIND_SAMPLE, 0, REG_TABLE_READY, 0, 0, 0},
    '{ROW_WORD, KIND_SAMPLE, -12345, 0, 0, 1, -12345}
  };

  lut_waveshaper_overdrive_top #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .kind_i       (kind_i),
    .sample_in_i  (sample_in_i),
    .table_addr_i (table_addr_i),
    .table_word_i (table_word_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sample_out_o (sample_out_o)
  );

  function automatic longint round_q(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint sat_q15(logic [15:0] v);
    return (v > UNITY_Q15) ? 32768 : longint'(v);
  endfunction

  function automatic void lut_span(input logic signed [SAMPLE_W-1:0] s, output int i0,
                                   output int i1, output longint frac);
    longint xd;
    longint pos;
    xd = clamp(round_q(longint'(s) * longint'(gain_q10), 10), -32768, 32768);
    pos = (xd + 32768) * (TABLE_DEPTH - 1);
    i0 = int'(pos >>> 16);
    if (i0 > TABLE_DEPTH - 1) i0 = TABLE_DEPTH - 1;
    i1 = (i0 + 1 > TABLE_DEPTH - 1) ? TABLE_DEPTH - 1 : i0 + 1;
    frac = pos & 64'hFFFF;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    case (idx)
      REG_DRIVE_GAIN: gain_q10 = value[14:0];
      REG_TONE_COEFF: tone_a0 = value;
      REG_WET_VOLUME: wet_level = value;
      REG_MIX_AMOUNT: blend = value;
      REG_EFFECT_ENABLED: fx_on = value[0];
      REG_TABLE_READY: lut_live = value[0];
      default: ;
    endcase
  endfunction

  // Returns 1 when the word produces an output sample.
  function automatic bit predict_sample_out(drive_word_t w, output logic signed [15:0] y_out);
    longint x, frac, y0, y1, ws, a0, lp, vol, wet, m, y, mag;
    int i0, i1;
    y_out = '0;
    if (w.kind == KIND_TABLE) begin
      shape_lut[w.addr] = w.word;
      lut_written[w.addr] = 1'b1;
      return 1'b0;
    end
    if (!lut_live) begin
      y_out = w.sample;
      return 1'b1;
    end
    x = longint'($signed(w.sample));
    lut_span(w.sample, i0, i1, frac);
    y0 = longint'(shape_lut[i0]);
    y1 = longint'(shape_lut[i1]);
    ws = y0 + round_q((y1 - y0) * frac, 16);
    a0 = sat_q15(tone_a0);
    lp = clamp(round_q(a0 * ws * 256 + (32768 - a0) * lowpass_z, 15), -8388608, 8388607);
    lowpass_z = lp;
    vol = sat_q15(wet_level);
    wet = round_q(lp * vol, 15);
    m = fx_on ? sat_q15(blend) : 0;
    y = clamp(round_q((32768 - m) * x * 256 + m * wet, 15), -8388608, 8388608);
    mag = (y < 0) ? -y : y;
    mag = (mag * 32767) >>> 23;
    y_out = 16'((y < 0) ? -mag : mag);
    return 1'b1;
  endfunction

  function automatic drive_word_t table_entry(int addr);
    drive_word_t w;
    w.kind = KIND_TABLE;
    w.sample = 16'($urandom);
    w.addr = TADDR_W'(addr);
    w.word = 16'(int'($urandom_range(0, 65534)) - 32767);
    return w;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] draw_sample();
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 3))
        0: return 16'sh7FFF;
        1: return 16'sh8000;
        2: return 16'sh0000;
        default: return 16'shFFFF;
      endcase
    end
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] draw_q15();
    case ($urandom_range(0, 4))
      0: return 16'd0;
      1: return UNITY_Q15;
      2: return 16'($urandom_range(0, 32768));
      3: return 16'($urandom);
      default: return 16'($urandom_range(100, 4000));
    endcase
  endfunction

  function automatic logic [15:0] draw_gain();
    case ($urandom_range(0, 4))
      0: return 16'd1024;
      1: return 16'd32767;
      2: return 16'($urandom_range(1024, 32767));
      3: return 16'($urandom);
      default: return 16'($urandom_range(1024, 4096));
    endcase
  endfunction

  task automatic push_word(drive_word_t w, bit typed, logic signed [15:0] typed_val);
    int gap;
    logic signed [15:0] y;
    gap = sender_calm ? 0 : $urandom_range(0, 17);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= w.kind;
    sample_in_i <= w.sample;
    table_addr_i <= w.addr;
    table_word_i <= w.word;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (predict_sample_out(w, y)) sample_out_due.push_back(typed ? typed_val : y);
  endtask

  // Table entries that the sample is about to read get written first.
  task automatic shape_sample(logic signed [15:0] s, bit typed, logic signed [15:0] typed_val);
    drive_word_t w;
    int i0, i1;
    longint frac;
    if (lut_live) begin
      lut_span(s, i0, i1, frac);
      if (!lut_written[i0]) push_word(table_entry(i0), 1'b0, '0);
      if (!lut_written[i1]) push_word(table_entry(i1), 1'b0, '0);
    end
    w.kind = KIND_SAMPLE;
    w.sample = s;
    w.addr = TADDR_W'($urandom);
    w.word = 16'($urandom);
    push_word(w, typed, typed_val);
  endtask

  task automatic wait_settled();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sample_out_due.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    apply_reg(idx, value);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic pick_settings();
    wait_settled();
    write_reg(REG_DRIVE_GAIN, draw_gain());
    write_reg(REG_TONE_COEFF, draw_q15());
    write_reg(REG_WET_VOLUME, draw_q15());
    write_reg(REG_MIX_AMOUNT, draw_q15());
    write_reg(REG_EFFECT_ENABLED, {15'($urandom), 1'($urandom_range(0, 1))});
    write_reg(REG_TABLE_READY, {15'($urandom), 1'($urandom_range(0, 5) != 0)});
    if ($urandom_range(0, 2) == 0) begin
      write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, 16'($urandom));
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (sample_out_due.size() == 0) begin
        $display("%0t: sample_out expected none, got %0d", $time, sample_out_o);
        mismatches++;
      end else begin
        due_word = sample_out_due.pop_front();
        if (sample_out_o !== due_word) begin
          $display("%0t: sample_out expected %0d, got %0d", $time, due_word, sample_out_o);
          mismatches++;
        end
      end
    end
  end

  // The receiver stalls before taking each word: a drawn hold, none when calm, a set one at words 150 and 650.
  initial begin
    out_stall_i = 1'b0;
    words_taken = 0;
    receiver_calm = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (words_taken == 150 || words_taken == 650) begin
        hold_cycles = 400;
      end else begin
        hold_cycles = receiver_calm ? 0 : $urandom_range(0, 17);
      end
      if (hold_cycles > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold_cycles) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      words_taken++;
      if (words_taken % 40 == 0) receiver_calm = ($urandom_range(0, 3) == 0);
    end
  end

  initial begin
    drive_word_t w;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    kind_i = KIND_SAMPLE;
    sample_in_i = '0;
    table_addr_i = '0;
    table_word_i = '0;
    mismatches = 0;
    sender_calm = 1'b0;
    lut_written = '0;
    lowpass_z = 0;
    gain_q10 = 15'd1024;
    tone_a0 = 16'd16384;
    wet_level = UNITY_Q15;
    blend = 16'd0;
    fx_on = 1'b0;
    lut_live = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (script[i]) begin
      if (script[i].op == ROW_REG) begin
        wait_settled();
        write_reg(CFG_IDX_W'(script[i].sel), CFG_DATA_W'(script[i].data));
      end else if (script[i].kind == KIND_TABLE) begin
        w.kind = KIND_TABLE;
        w.sample = 16'(script[i].sample);
        w.addr = TADDR_W'(script[i].sel);
        w.word = 16'(script[i].data);
        push_word(w, 1'b0, '0);
      end else begin
        shape_sample(16'(script[i].sample), script[i].typed, 16'(script[i].result));
      end
    end

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      pick_settings();
      sender_calm = ($urandom_range(0, 3) == 0);
      repeat (PHASE_WORDS) begin
        if ($urandom_range(0, 4) == 0) begin
          push_word(table_entry($urandom_range(0, TABLE_DEPTH - 1)), 1'b0, '0);
        end else begin
          shape_sample(draw_sample(), 1'b0, '0);
        end
      end
    end

    wait_settled();
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
